[rtl/ddo_pkg.sv]
package ddo_pkg;

    // Q3.28 angle constants
    localparam logic signed [31:0] PI_Q      = 32'sd843314857;
    localparam logic signed [31:0] HALF_PI_Q = 32'sd421657428;
    localparam logic        [31:0] TWO_PI_Q  = 32'd1686629713;

    // floor(2^62 / 2pi_q), quotient estimate for the heading reduction
    localparam logic        [31:0] TWO_PI_RECIP = 32'((64'd1 << 62) / 64'(TWO_PI_Q));

    // CORDIC pre-scaled start vector, Q2.30
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // Magnitude clamps applied after rounding
    localparam logic [95:0] LIM62 = 96'd1 << 62;
    localparam logic [95:0] LIM40 = 96'd1 << 40;

    // Register indexes
    localparam logic [1:0] REG_DIST_PER_COUNT = 2'd0;
    localparam logic [1:0] REG_INV_WHEEL_BASE = 2'd1;
    localparam logic [1:0] REG_SAMPLE_RATE    = 2'd2;

    localparam logic [31:0] DPC_RESET  = 32'd70838;
    localparam logic [31:0] IWB_RESET  = 32'd83886080;
    localparam logic [15:0] RATE_RESET = 16'd250;

    // atan(2^-i) in Q3.28; beyond the table the angle equals 2^-i
    function automatic logic signed [31:0] atan_q(input logic [4:0] i);
        logic signed [31:0] a;
        case (i)
            5'd0: a = 32'sd210828714;
            5'd1: a = 32'sd124459457;
            5'd2: a = 32'sd65760959;
            5'd3: a = 32'sd33381290;
            5'd4: a = 32'sd16755422;
            5'd5: a = 32'sd8385879;
            5'd6: a = 32'sd4193963;
            5'd7: a = 32'sd2097109;
            5'd8: a = 32'sd1048571;
            5'd9: a = 32'sd524287;
            default: a = 32'sd268435456 >>> i;
        endcase
        return a;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[rtl/differential_drive_odometry_unit.sv]
// Differential-drive wheel odometry. Each input transaction carries the raw right and left
// 32-bit encoder counts; the block differences them against the last sample (modulo 2^32,
// left inverted), scales to wheel travel, and returns one result transaction with the new
// x/y position (Q16.16), heading (Q3.28, wrapped to +-pi) and saturated linear and angular
// speed (Q16.16). All products go through one 32x32 multiplier, used twice per product and
// accumulated, under a small sequencer that runs 9 products in turn. cos/sin of the old
// heading come from a CORDIC running CORDIC_STEPS iterations alongside. The heading step is
// reduced modulo 2pi on the same multiplier: a quotient estimate from a fixed reciprocal,
// then the exact remainder, trimmed by at most three compare-and-subtract steps that overlap
// the later products. The sequencer sets the pace: a result is presented once the last
// product and the trim are done and the output register is free, and only then can the next
// transaction be taken, so the block finishes each item before it takes another. The input is
// not ready meanwhile; a finished result sits in the output register while the next item is
// taken, and a second finished result waits in the sequencer until that register frees.
module differential_drive_odometry_unit
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration write port
    input  logic         i_cfg_wr_en,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_wdata,
    // input stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [63:0]  i_s_tdata,   // right_count[31:0], left_count[63:32]
    // result stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [159:0] o_m_tdata    // x_pos[31:0], y_pos[63:32], heading[94:64],
                                      // linear_speed[126:95], angular_speed[158:127]
);

    localparam int IW = $clog2(CORDIC_STEPS);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_WAIT} t_state;
    typedef enum logic [3:0] {
        OP_TR, OP_TL, OP_STEP, OP_QEST, OP_QMUL, OP_LIN, OP_ANG, OP_DX, OP_DY
    } t_op;

    t_state r_state;
    t_op    r_op;
    logic [1:0] r_ph;

    // configuration
    logic [31:0] r_dpc, r_iwb;
    logic [15:0] r_rate;

    // odometry state
    logic [31:0]        r_prev_r, r_prev_l;
    logic signed [31:0] r_pos_x, r_pos_y, r_angle;

    // per-item values
    logic signed [31:0] r_rdiff, r_ldiff;
    logic signed [55:0] r_tr, r_tl;         // wheel travel, Q.24
    logic signed [63:0] r_step;             // heading step, Q.28
    logic signed [31:0] r_lin, r_ang;

    // shared multiplier
    logic [63:0] r_pp;
    logic [95:0] r_acc;

    // CORDIC
    logic               r_cor_busy, r_flip;
    logic [IW-1:0]      r_cor_i;
    logic signed [33:0] r_cx, r_cy;
    logic signed [31:0] r_cz;

    // modulo-2pi reduction: quotient estimate, then remainder trim
    logic        r_mod_busy, r_mod_neg;
    logic [31:0] r_qest;
    logic [32:0] r_mod_rem;

    // output register
    logic         r_out_valid;
    logic [159:0] r_out_data;

    // ---- derived values -------------------------------------------------
    logic signed [56:0] w_sum, w_diff;
    logic [56:0]        w_sum_mag, w_diff_mag;
    logic [47:0]        w_mean_mag;
    logic signed [33:0] w_cos, w_sin;
    logic [31:0]        w_cos_mag, w_sin_mag;
    logic [31:0]        w_rdiff_mag, w_ldiff_mag;
    logic [63:0]        w_step_mag;

    always_comb begin
        w_sum       = 57'(r_tr) + 57'(r_tl);
        w_diff      = 57'(r_tr) - 57'(r_tl);
        w_sum_mag   = w_sum[56]  ? 57'(-w_sum)  : 57'(w_sum);
        w_diff_mag  = w_diff[56] ? 57'(-w_diff) : 57'(w_diff);
        // mean travel: half the sum, rounded to Q.16, half away from zero
        w_mean_mag  = 48'(w_sum_mag >> 9) + 48'(w_sum_mag[8]);
        w_cos       = r_flip ? -r_cx : r_cx;
        w_sin       = r_flip ? -r_cy : r_cy;
        w_cos_mag   = 32'(w_cos[33] ? -w_cos : w_cos);
        w_sin_mag   = 32'(w_sin[33] ? -w_sin : w_sin);
        w_rdiff_mag = r_rdiff[31] ? 32'(-r_rdiff) : 32'(r_rdiff);
        w_ldiff_mag = r_ldiff[31] ? 32'(-r_ldiff) : 32'(r_ldiff);
        w_step_mag  = r_step[63] ? 64'(-r_step) : 64'(r_step);
    end

    // ---- operand selection for the shared multiplier --------------------
    logic [63:0] w_mag;
    logic [31:0] w_b;
    logic [4:0]  w_shamt;
    logic [95:0] w_lim;
    logic        w_neg;

    always_comb begin
        w_mag   = 64'(w_rdiff_mag);
        w_b     = r_dpc;
        w_shamt = 5'd8;
        w_lim   = LIM62;
        w_neg   = r_rdiff[31];
        case (r_op)
            OP_TR: begin
            end
            OP_TL: begin
                // left count is inverted
                w_mag = 64'(w_ldiff_mag);
                w_neg = ~r_ldiff[31];
            end
            OP_STEP: begin
                w_mag   = 64'(w_diff_mag);
                w_b     = r_iwb;
                w_shamt = 5'd20;
                w_neg   = w_diff[56];
            end
            OP_QEST: begin
                // top of |step| times 2^62/2pi; never above the true quotient
                w_mag = w_step_mag >> 31;
                w_b   = TWO_PI_RECIP;
            end
            OP_QMUL: begin
                w_mag = 64'(r_qest);
                w_b   = TWO_PI_Q;
            end
            OP_LIN: begin
                w_mag   = 64'(w_sum_mag);
                w_b     = 32'(r_rate);
                w_shamt = 5'd9;
                w_lim   = LIM40;
                w_neg   = w_sum[56];
            end
            OP_ANG: begin
                w_mag   = w_step_mag;
                w_b     = 32'(r_rate);
                w_shamt = 5'd12;
                w_lim   = LIM40;
                w_neg   = r_step[63];
            end
            OP_DX: begin
                w_mag   = 64'(w_mean_mag);
                w_b     = w_cos_mag;
                w_shamt = 5'd30;
                w_lim   = LIM40;
                w_neg   = w_sum[56] ^ w_cos[33];
            end
            OP_DY: begin
                w_mag   = 64'(w_mean_mag);
                w_b     = w_sin_mag;
                w_shamt = 5'd30;
                w_lim   = LIM40;
                w_neg   = w_sum[56] ^ w_sin[33];
            end
            default: begin
            end
        endcase
    end

    // round half away from zero, clamp magnitude, restore sign
    logic [95:0]        w_rfull, w_rclamp;
    logic signed [63:0] w_res;

    always_comb begin
        w_rfull  = (r_acc >> w_shamt) + 96'(r_acc[7'(w_shamt) - 7'd1]);
        w_rclamp = (w_rfull > w_lim) ? w_lim : w_rfull;
        w_res    = w_neg ? -$signed(w_rclamp[63:0]) : $signed(w_rclamp[63:0]);
    end

    // ---- CORDIC step ----------------------------------------------------
    logic signed [33:0] w_cdx, w_cdy;
    logic signed [31:0] w_atan;
    logic signed [31:0] w_fold_z;
    logic               w_fold_flip;

    always_comb begin
        w_cdx  = r_cy >>> r_cor_i;
        w_cdy  = r_cx >>> r_cor_i;
        w_atan = atan_q(5'(r_cor_i));
        // bring the old heading into +-pi/2
        w_fold_z    = r_angle;
        w_fold_flip = 1'b0;
        if (r_angle > HALF_PI_Q) begin
            w_fold_z    = r_angle - PI_Q;
            w_fold_flip = 1'b1;
        end else if (r_angle < -HALF_PI_Q) begin
            w_fold_z    = r_angle + PI_Q;
            w_fold_flip = 1'b1;
        end
    end

    // ---- heading wrap ---------------------------------------------------
    logic signed [32:0] w_rem_s, n_head;

    always_comb begin
        // remainder takes the sign of the step (truncating modulo)
        w_rem_s = r_mod_neg ? -$signed({2'b00, r_mod_rem[30:0]})
                            : $signed({2'b00, r_mod_rem[30:0]});
        n_head  = 33'(r_angle) + w_rem_s;
        if (n_head > 33'(PI_Q)) begin
            n_head = n_head - $signed({1'b0, TWO_PI_Q});
        end else if (n_head < -33'(PI_Q)) begin
            n_head = n_head + $signed({1'b0, TWO_PI_Q});
        end
    end

    logic w_accept, w_out_free, w_mul_hold, w_emit;

    assign w_accept   = i_s_tvalid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_m_tready;
    // position steps need the CORDIC result
    assign w_mul_hold = (r_op == OP_DX) && r_cor_busy;
    assign w_emit     = (r_state == S_WAIT) && !r_mod_busy && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_TR;
            r_ph        <= 2'd0;
            r_dpc       <= DPC_RESET;
            r_iwb       <= IWB_RESET;
            r_rate      <= RATE_RESET;
            r_prev_r    <= '0;
            r_prev_l    <= '0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_angle     <= '0;
            r_cor_busy  <= 1'b0;
            r_mod_busy  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_DIST_PER_COUNT: r_dpc  <= i_cfg_wdata;
                    REG_INV_WHEEL_BASE: r_iwb  <= i_cfg_wdata;
                    REG_SAMPLE_RATE:    r_rate <= i_cfg_wdata[15:0];
                    default: ;
                endcase
            end

            // CORDIC, started on acceptance, runs on its own
            if (w_accept) begin
                r_cor_busy <= 1'b1;
                r_cor_i    <= '0;
                r_cx       <= CORDIC_GAIN;
                r_cy       <= '0;
                r_cz       <= w_fold_z;
                r_flip     <= w_fold_flip;
            end else if (r_cor_busy) begin
                if (!r_cz[31]) begin
                    r_cx <= r_cx - w_cdx;
                    r_cy <= r_cy + w_cdy;
                    r_cz <= r_cz - w_atan;
                end else begin
                    r_cx <= r_cx + w_cdx;
                    r_cy <= r_cy - w_cdy;
                    r_cz <= r_cz + w_atan;
                end
                if (r_cor_i == IW'(CORDIC_STEPS - 1)) begin
                    r_cor_busy <= 1'b0;
                end else begin
                    r_cor_i <= r_cor_i + 1'b1;
                end
            end

            // remainder trim: the estimate is at most three short
            if (r_mod_busy) begin
                if (r_mod_rem >= 33'(TWO_PI_Q)) begin
                    r_mod_rem <= r_mod_rem - 33'(TWO_PI_Q);
                end else begin
                    r_mod_busy <= 1'b0;
                end
            end

            if (r_out_valid && i_m_tready && !w_emit) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_rdiff  <= i_s_tdata[31:0]  - r_prev_r;
                        r_ldiff  <= i_s_tdata[63:32] - r_prev_l;
                        r_prev_r <= i_s_tdata[31:0];
                        r_prev_l <= i_s_tdata[63:32];
                        r_op     <= OP_TR;
                        r_ph     <= 2'd0;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (!w_mul_hold) begin
                        r_ph <= r_ph + 1'b1;
                        case (r_ph)
                            2'd0: r_pp <= 64'(w_mag[31:0]) * 64'(w_b);
                            2'd1: begin
                                r_acc <= 96'(r_pp);
                                r_pp  <= 64'(w_mag[63:32]) * 64'(w_b);
                            end
                            2'd2: r_acc <= r_acc + {r_pp, 32'd0};
                            default: begin
                                case (r_op)
                                    OP_TR:   r_tr <= w_res[55:0];
                                    OP_TL:   r_tl <= w_res[55:0];
                                    OP_STEP: begin
                                        r_step    <= w_res;
                                        r_mod_neg <= w_res[63];
                                    end
                                    OP_QEST: r_qest <= r_acc[62:31];
                                    OP_QMUL: begin
                                        r_mod_rem  <= 33'(w_step_mag - r_acc[63:0]);
                                        r_mod_busy <= 1'b1;
                                    end
                                    OP_LIN:  r_lin <= sat32(w_res);
                                    OP_ANG:  r_ang <= sat32(w_res);
                                    OP_DX:   r_pos_x <= sat32(64'(r_pos_x) + w_res);
                                    OP_DY:   r_pos_y <= sat32(64'(r_pos_y) + w_res);
                                    default: ;
                                endcase
                                if (r_op == OP_DY) begin
                                    r_state <= S_WAIT;
                                end else begin
                                    r_op <= t_op'(r_op + 1'b1);
                                end
                            end
                        endcase
                    end
                end
                S_WAIT: begin
                    if (w_emit) begin
                        r_angle     <= n_head[31:0];
                        r_out_data  <= {1'b0, r_ang, r_lin, n_head[30:0], r_pos_y, r_pos_x};
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

[tb/tb_differential_drive_odometry_unit.sv]
module tb_differential_drive_odometry_unit;
    import ddo_pkg::*;

    // index with no register behind it; writes there must be ignored
    localparam logic [1:0] REG_UNMAPPED = 2'd3;
    localparam int         SETTLE_CYCLES = 120;   // quiet time once every pose is back

    typedef struct {
        logic signed [31:0] x_pos;
        logic signed [31:0] y_pos;
        logic        [30:0] heading;
        logic signed [31:0] linear_speed;
        logic signed [31:0] angular_speed;
    } t_pose;

    // Pose scoreboard: tracks odometry state, predicts each pose, checks results in order
    class t_odo_scoreboard;
        logic [31:0]        dist_per_count, inv_wheel_base;
        logic [15:0]        sample_rate;
        logic [31:0]        last_right, last_left;
        logic signed [31:0] x_acc, y_acc, theta;
        t_pose              expected_poses[$];
        int                 errors;

        function new();
            dist_per_count = DPC_RESET;
            inv_wheel_base = IWB_RESET;
            sample_rate    = RATE_RESET;
            last_right = '0;
            last_left  = '0;
            x_acc = '0;
            y_acc = '0;
            theta = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_DIST_PER_COUNT: dist_per_count = val;
                REG_INV_WHEEL_BASE: inv_wheel_base = val;
                REG_SAMPLE_RATE:    sample_rate    = val[15:0];
                default: ;
            endcase
        endfunction

        // round(a*b / 2^s) half away from zero, magnitude clamped to lim
        function longint scaled_round(longint a, longint unsigned b, int s,
                                      longint unsigned lim);
            bit              neg;
            longint unsigned mag, hi, lo, r;
            neg = a < 0;
            mag = neg ? 64'd0 - longint'(a) : a;
            hi  = (mag >> 32) * b;
            lo  = (mag & 64'hFFFF_FFFF) * b;
            if (hi > (lim >> (32 - s))) begin
                r = lim;
            end else begin
                r = (hi << (32 - s)) + (lo >> s) + ((lo >> (s - 1)) & 64'd1);
                if (r > lim) r = lim;
            end
            return neg ? -longint'(r) : longint'(r);
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // rotation-mode CORDIC: cos/sin (Q2.30) of a Q3.28 angle in [-pi, pi]
        function void rotate(longint z, output longint c, output longint s);
            longint x, y, t, a, dx, dy;
            bit     flip;
            x = longint'(CORDIC_GAIN);
            y = 0;
            flip = 1'b0;
            if (z > longint'(HALF_PI_Q)) begin
                z = z - longint'(PI_Q);
                flip = 1'b1;
            end else if (z < -longint'(HALF_PI_Q)) begin
                z = z + longint'(PI_Q);
                flip = 1'b1;
            end
            for (int i = 0; i < 24; i++) begin
                case (i)
                    0: a = 210828714;
                    1: a = 124459457;
                    2: a = 65760959;
                    3: a = 33381290;
                    4: a = 16755422;
                    5: a = 8385879;
                    6: a = 4193963;
                    7: a = 2097109;
                    8: a = 1048571;
                    9: a = 524287;
                    default: a = (64'sd1 << 28) >>> i;
                endcase
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    t = x - dx;
                    y = y + dy;
                    z = z - a;
                end else begin
                    t = x + dx;
                    y = y - dy;
                    z = z + a;
                end
                x = t;
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function logic signed [31:0] move_axis(logic signed [31:0] p, longint mean,
                                               longint trig);
            longint          a;
            longint unsigned b;
            a = (trig < 0) ? -mean : mean;
            b = (trig < 0) ? -trig : trig;
            return 32'(clamp32(longint'(p) + scaled_round(a, b, 30, 64'd1 << 40)));
        endfunction

        // dead-reckoning update for one accepted encoder sample
        function void note_sample(logic [31:0] r, logic [31:0] l);
            logic signed [31:0] dr, dl;
            longint             drc, dlc, dpc, tr, tl, sum, diff, turn, mean, c, s, h;
            t_pose              p;
            dr  = r - last_right;
            dl  = l - last_left;
            drc = longint'(dr);
            dlc = -longint'(dl);
            dpc = longint'({32'd0, dist_per_count});
            tr  = scaled_round(drc * dpc, 1, 8, 64'd1 << 62);
            tl  = scaled_round(dlc * dpc, 1, 8, 64'd1 << 62);
            sum  = tr + tl;
            diff = tr - tl;
            turn = scaled_round(diff, inv_wheel_base, 20, 64'd1 << 62);
            p.linear_speed  = 32'(clamp32(scaled_round(sum, sample_rate, 9, 64'd1 << 40)));
            p.angular_speed = 32'(clamp32(scaled_round(turn, sample_rate, 12, 64'd1 << 40)));
            mean = scaled_round(sum, 1, 9, 64'd1 << 62);
            rotate(longint'(theta), c, s);
            x_acc = move_axis(x_acc, mean, c);
            y_acc = move_axis(y_acc, mean, s);
            // heading wraps once either way after the step is reduced mod 2pi
            h = longint'(theta) + turn % longint'(TWO_PI_Q);
            if (h > longint'(PI_Q)) h = h - longint'(TWO_PI_Q);
            if (h < -longint'(PI_Q)) h = h + longint'(TWO_PI_Q);
            theta = h[31:0];
            last_right = r;
            last_left  = l;
            p.x_pos   = x_acc;
            p.y_pos   = y_acc;
            p.heading = theta[30:0];
            expected_poses.push_back(p);
        endfunction

        function void check_pose(logic [159:0] d);
            t_pose e;
            if (expected_poses.size() == 0) begin
                $display("%0t: unexpected result transaction %h", $time, d);
                errors++;
                return;
            end
            e = expected_poses.pop_front();
            if (d[31:0] !== e.x_pos) begin
                $display("%0t: x_pos exp %h got %h", $time, e.x_pos, d[31:0]);
                errors++;
            end
            if (d[63:32] !== e.y_pos) begin
                $display("%0t: y_pos exp %h got %h", $time, e.y_pos, d[63:32]);
                errors++;
            end
            if (d[94:64] !== e.heading) begin
                $display("%0t: heading exp %h got %h", $time, e.heading, d[94:64]);
                errors++;
            end
            if (d[126:95] !== e.linear_speed) begin
                $display("%0t: linear_speed exp %h got %h", $time, e.linear_speed,
                         d[126:95]);
                errors++;
            end
            if (d[158:127] !== e.angular_speed) begin
                $display("%0t: angular_speed exp %h got %h", $time, e.angular_speed,
                         d[158:127]);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_wr_en = 1'b0;
    logic [1:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_wdata = '0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [63:0]  i_s_tdata = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [159:0] o_m_tdata;

    t_odo_scoreboard sb = new();

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_cycles_left = 0;
    bit          hold_request = 1'b0;
    logic [31:0] cur_right = '0, cur_left = '0;

    always #1 i_clk = ~i_clk;

    differential_drive_odometry_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // result side: check each accepted transaction, then choose next tready.
    // A hold-off request stalls the receiver for a long stretch so the block backs up.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_pose(o_m_tdata);
        end
        if (hold_request) begin
            hold_cycles_left = 400;
            hold_request = 1'b0;
        end
        if (hold_cycles_left > 0) begin
            hold_cycles_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // sender: valid stays high across back-to-back transactions, dropped only to idle
    task automatic send_sample(input logic [31:0] r, input logic [31:0] l);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {l, r};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_sample(r, l);
    endtask

    // sender pauses until every expected pose is back, then lets the block settle
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.expected_poses.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one write strobe, with wr_en low again before the next write
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    // encoder walk: mostly small moves, some big jumps, full-range values and wrap crossings
    function automatic logic [31:0] next_count(logic [31:0] prev);
        case ($urandom_range(7))
            5: return prev + $urandom_range(2097152) - 32'd1048576;
            6: return $urandom;
            7: return ($urandom_range(1) ? 32'h7FFF_FF00 : 32'h8000_0000)
                      + $urandom_range(511) - 32'd256;
            default: return prev + $urandom_range(4000) - 32'd2000;
        endcase
    endfunction

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: first sample after reset, count extremes, straight runs and spins
        send_sample(32'd1000, 32'hFFFF_FC18);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF);
        send_sample(32'h0000_0000, 32'h0000_0000);
        send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(32'hFFFF_FFFF, 32'h0000_0001);
        for (int i = 0; i < 8; i++) begin
            send_sample(32'd40000 * (i + 1), 32'hFFFF_FFFF - 32'd40000 * i);
        end
        for (int i = 0; i < 6; i++) begin
            send_sample(32'd500000 * (i + 1), 32'd500000 * (i + 1));
        end
        cur_right = 32'd3000000;
        cur_left  = 32'd3000000;
        drain();

        // unmapped index must leave the registers alone
        write_reg(REG_UNMAPPED, 32'hDEAD_BEEF);

        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin send_idle_pct = 14; recv_idle_pct = 50; end
                1: begin send_idle_pct = 50; recv_idle_pct = 14; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int ph = 0; ph < 4; ph++) begin
                case (ph)
                    0: begin
                        write_reg(REG_DIST_PER_COUNT, $urandom_range(200000, 1));
                        write_reg(REG_INV_WHEEL_BASE, $urandom_range(32'h2000_0000, 1));
                        write_reg(REG_SAMPLE_RATE, $urandom_range(2000, 1));
                    end
                    1: begin
                        write_reg(REG_DIST_PER_COUNT, 32'hFFFF_FFFF);
                        write_reg(REG_INV_WHEEL_BASE, 32'hFFFF_FFFF);
                        write_reg(REG_SAMPLE_RATE, 32'h0000_FFFF);
                    end
                    2: begin
                        write_reg(REG_DIST_PER_COUNT, 32'd0);
                        write_reg(REG_INV_WHEEL_BASE, 32'd0);
                        write_reg(REG_SAMPLE_RATE, 32'd0);
                    end
                    default: begin
                        write_reg(REG_DIST_PER_COUNT, $urandom);
                        write_reg(REG_INV_WHEEL_BASE, $urandom);
                        write_reg(REG_SAMPLE_RATE, $urandom_range(65535, 1));
                    end
                endcase
                for (int n = 0; n < 75; n++) begin
                    // one long receiver stall per mode while the sender keeps pushing
                    if (ph == 1 && n == 10) hold_request = 1'b1;
                    cur_right = next_count(cur_right);
                    cur_left  = next_count(cur_left);
                    send_sample(cur_right, cur_left);
                end
                drain();
            end
        end

        if (sb.errors == 0) begin
            $display("** differential_drive_odometry_unit: PASSED **");
        end else begin
            $display("** differential_drive_odometry_unit: FAILED **");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("** differential_drive_odometry_unit: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
rtl/ddo_pkg.sv
rtl/differential_drive_odometry_unit.sv
tb/tb_differential_drive_odometry_unit.sv
